[rtl/fwm_pkg.sv]
// ----------------------------------------------------------------------------
// Frame window multiplier package
// Shared constants, window codes, sequencer codes and the command/status
// structs that join the controller and the datapath.
// ----------------------------------------------------------------------------
package fwm_pkg;

	// configuration registers
	localparam int WT_W      = 3;
	localparam int FL_W      = 13;
	localparam int CFG_W     = 13;
	localparam int CFG_IDX_W = 1;

	localparam logic [CFG_IDX_W-1:0] REG_WINDOW_TYPE  = 1'b0;
	localparam logic [CFG_IDX_W-1:0] REG_FRAME_LENGTH = 1'b1;

	localparam logic [WT_W-1:0] WIN_RECT     = 3'd0;
	localparam logic [WT_W-1:0] WIN_HANN     = 3'd1;
	localparam logic [WT_W-1:0] WIN_HAMMING  = 3'd2;
	localparam logic [WT_W-1:0] WIN_BLACKMAN = 3'd3;
	localparam logic [WT_W-1:0] WIN_TUKEY    = 3'd4;

	localparam logic [WT_W-1:0] WT_RESET = WIN_HANN;
	localparam logic [FL_W-1:0] FL_RESET = 13'd1024;

	// arithmetic widths
	localparam int PH_BITS = 24;   // phase as a fraction of one turn
	localparam int MUL_W   = 32;   // multiplier operand width
	localparam int PROD_W  = 64;
	localparam int QUO_W   = 32;   // quotient bits kept by the divider
	localparam int STEP    = 4;    // quotient bits per divider cycle
	localparam int ACC_W   = 34;   // signed Q30 accumulators
	localparam int MAG_W   = 31;   // Q30 magnitudes up to one
	localparam int K_W     = 3;
	localparam int TD_W    = 8;

	localparam logic [K_W-1:0] N_TERMS = 3'd7;

	localparam logic [MAG_W-1:0] ONE30  = 31'd1073741824;
	localparam logic [MAG_W-1:0] K_HALF = 31'd536870912;
	localparam logic [MAG_W-1:0] K_054  = 31'd579820585;
	localparam logic [MAG_W-1:0] K_046  = 31'd493921239;
	localparam logic [MAG_W-1:0] K_042  = 31'd450971566;
	localparam logic [MAG_W-1:0] K_008  = 31'd85899346;
	localparam logic [MUL_W-1:0] PI30   = 32'hC90FDAA2;

	typedef enum logic [3:0] {
		OP_NONE,
		OP_LOAD,
		OP_PHASE,
		OP_FOLD,
		OP_X,
		OP_X2,
		OP_TDIV,
		OP_TACC,
		OP_CEND,
		OP_KMUL,
		OP_KACC,
		OP_COEF,
		OP_RES
	} op_t;

	typedef enum logic [4:0] {
		S_IDLE,
		S_SETUP,
		S_PHASE,
		S_PWAIT,
		S_FOLD,
		S_FOLD_W,
		S_X,
		S_X_W,
		S_X2,
		S_TM_W,
		S_TDIV,
		S_TWAIT,
		S_TACC,
		S_CEND,
		S_KMUL,
		S_KM_W,
		S_KACC,
		S_COEF,
		S_CO_W,
		S_RES
	} state_t;

	typedef struct packed {
		op_t            op;
		logic           second;
		logic [K_W-1:0] k;
	} cmd_t;

	typedef struct packed {
		logic pass;
		logic flat;
		logic two_cos;
		logic div_done;
	} sts_t;

	// divisor of the k-th Taylor term: (2k-1)(2k)
	function automatic logic [TD_W-1:0] term_divisor(input logic [K_W-1:0] k);
		logic [TD_W-1:0] d;
		unique case (k)
			3'd1:    d = 8'd2;
			3'd2:    d = 8'd12;
			3'd3:    d = 8'd30;
			3'd4:    d = 8'd56;
			3'd5:    d = 8'd90;
			3'd6:    d = 8'd132;
			3'd7:    d = 8'd182;
			default: d = 8'd2;
		endcase
		return d;
	endfunction

	// floor(2^32 / divisor) of the k-th Taylor term
	function automatic logic [MUL_W-1:0] term_recip(input logic [K_W-1:0] k);
		logic [MUL_W-1:0] m;
		unique case (k)
			3'd1:    m = 32'd2147483648;
			3'd2:    m = 32'd357913941;
			3'd3:    m = 32'd143165576;
			3'd4:    m = 32'd76695844;
			3'd5:    m = 32'd47721858;
			3'd6:    m = 32'd32537631;
			3'd7:    m = 32'd23598721;
			default: m = 32'd2147483648;
		endcase
		return m;
	endfunction

endpackage

[rtl/fwm_div.sv]
// ----------------------------------------------------------------------------
// Frame window multiplier divider
// Iterative restoring divider, a few quotient bits per cycle; keeps the low
// quotient bits.
// ----------------------------------------------------------------------------
module fwm_div #(
	parameter int DVD_W = 44,
	parameter int DSR_W = 14
) (
	input  logic                     clk,
	input  logic                     arst_n,
	input  logic                     start,
	input  logic [DVD_W-1:0]         dividend,
	input  logic [DSR_W-1:0]         divisor,
	output logic                     done,
	output logic [fwm_pkg::QUO_W-1:0] quotient
);

	localparam int STEPS = DVD_W / fwm_pkg::STEP;
	localparam int CNT_W = $clog2(STEPS + 1);

	logic [DVD_W-1:0]          dvd_q;
	logic [DSR_W-1:0]          dsr_q;
	logic [DSR_W-1:0]          rem_q;
	logic [fwm_pkg::QUO_W-1:0] quo_q;
	logic [CNT_W-1:0]          cnt_q;
	logic                      busy_q;
	logic                      done_q;

	logic [DSR_W-1:0]          rem_c;
	logic [fwm_pkg::QUO_W-1:0] quo_c;
	logic [DSR_W:0]            trial;
	logic                      qb;

	always_comb begin
		rem_c = rem_q;
		quo_c = quo_q;
		trial = '0;
		qb    = 1'b0;
		for (int i = 0; i < fwm_pkg::STEP; i++) begin
			trial = {rem_c, dvd_q[DVD_W-1-i]};
			qb    = (trial >= {1'b0, dsr_q});
			if (qb) begin
				trial = trial - {1'b0, dsr_q};
			end
			rem_c = trial[DSR_W-1:0];
			quo_c = {quo_c[fwm_pkg::QUO_W-2:0], qb};
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q <= 1'b0;
			done_q <= 1'b0;
			cnt_q  <= '0;
		end else begin
			done_q <= 1'b0;
			if (start) begin
				busy_q <= 1'b1;
				cnt_q  <= CNT_W'(STEPS);
			end else if (busy_q) begin
				cnt_q <= cnt_q - 1'b1;
				if (cnt_q == CNT_W'(1)) begin
					busy_q <= 1'b0;
					done_q <= 1'b1;
				end
			end
		end
	end

	always_ff @(posedge clk) begin
		if (start) begin
			dvd_q <= dividend;
			dsr_q <= divisor;
			rem_q <= '0;
			quo_q <= '0;
		end else if (busy_q) begin
			dvd_q <= dvd_q << fwm_pkg::STEP;
			rem_q <= rem_c;
			quo_q <= quo_c;
		end
	end

	assign done     = done_q;
	assign quotient = quo_q;

endmodule

[rtl/fwm_dp.sv]
// ----------------------------------------------------------------------------
// Frame window multiplier datapath
// Position counter, phase and cosine arithmetic on a shared multiplier and
// divider, window accumulation, coefficient scaling and the result register.
// ----------------------------------------------------------------------------
module fwm_dp #(
	parameter int MAX_FRAME    = 4096,
	parameter int SAMPLE_WIDTH = 24,
	parameter int COEF_WIDTH   = 18
) (
	input  logic                          clk,
	input  logic                          arst_n,
	input  fwm_pkg::cmd_t                 cmd,
	output fwm_pkg::sts_t                 sts,
	input  logic [fwm_pkg::WT_W-1:0]      window_type,
	input  logic [fwm_pkg::FL_W-1:0]      frame_length,
	input  logic signed [SAMPLE_WIDTH-1:0] sample_in,
	input  logic                          frame_start,
	output logic signed [SAMPLE_WIDTH-1:0] sample_out,
	output logic                          frame_last
);

	localparam int SW      = SAMPLE_WIDTH;
	localparam int F       = COEF_WIDTH - 1;
	localparam int PW      = (MAX_FRAME > 2) ? $clog2(MAX_FRAME) : 1;
	localparam int LW_MAX  = $clog2(MAX_FRAME + 1);
	localparam int LW      = (fwm_pkg::FL_W > LW_MAX) ? fwm_pkg::FL_W : LW_MAX;
	localparam int NW      = PW + 5;
	localparam int DVD_RAW = NW + fwm_pkg::PH_BITS;
	localparam int DVD_MIN = (DVD_RAW > fwm_pkg::MUL_W) ? DVD_RAW : fwm_pkg::MUL_W;
	localparam int DVD_W   = (DVD_MIN + fwm_pkg::STEP - 1) / fwm_pkg::STEP * fwm_pkg::STEP;
	localparam int DSR_W   = (PW + 1 > fwm_pkg::TD_W) ? PW + 1 : fwm_pkg::TD_W;
	localparam int ACC_W   = fwm_pkg::ACC_W;
	localparam int MAG_W   = fwm_pkg::MAG_W;
	localparam int MUL_W   = fwm_pkg::MUL_W;
	localparam int PROD_W  = fwm_pkg::PROD_W;

	localparam logic signed [ACC_W-1:0]  ONE_ACC = ACC_W'(fwm_pkg::ONE30);
	localparam logic signed [PROD_W-1:0] SMAX    = (64'sd1 <<< (SW - 1)) - 64'sd1;
	localparam logic signed [PROD_W-1:0] SMIN    = -(64'sd1 <<< (SW - 1));
	localparam logic signed [PROD_W-1:0] HALF_LSB = 64'sd1 <<< (F - 1);

	// state and payload registers
	logic [PW-1:0]           pos_q;
	logic [PW-1:0]           p_q;
	logic [PW-1:0]           n_q;
	logic signed [SW-1:0]    s_q;
	logic                    last_q;
	logic [1:0]              qd_q;
	logic [MUL_W-1:0]        x2_q;
	logic [MUL_W-1:0]        tv_q;
	logic signed [ACC_W-1:0] sum_q;
	logic signed [ACC_W-1:0] w_q;
	logic [MAG_W-1:0]        c_mag_q;
	logic                    c_neg_q;
	logic [MUL_W-1:0]        opa_q;
	logic [MUL_W-1:0]        opb_q;
	logic [PROD_W-1:0]       mul_q;
	logic signed [SW-1:0]    sample_out_q;
	logic                    frame_last_q;

	// load path
	logic [LW-1:0] fl_c;
	logic [LW-1:0] len_c;
	logic [PW-1:0] n_c;
	logic [PW-1:0] p_c;
	logic          last_c;

	always_comb begin
		fl_c = LW'(frame_length);
		priority if (fl_c == '0) begin
			len_c = LW'(1);
		end else if (fl_c > LW'(MAX_FRAME)) begin
			len_c = LW'(MAX_FRAME);
		end else begin
			len_c = fl_c;
		end
		n_c    = PW'(len_c - LW'(1));
		p_c    = frame_start ? '0 : pos_q;
		last_c = (p_c >= n_c);
	end

	// window path decisions
	logic [NW-1:0] p20;
	logic [NW-1:0] nx;
	logic [NW-1:0] n19;
	logic          tk_lo;
	logic          tk_hi;
	logic          is_tukey;
	logic [NW-1:0]    num_c;
	logic [DSR_W-1:0] den_c;

	always_comb begin
		p20      = (NW'(p_q) << 4) + (NW'(p_q) << 2);
		nx       = NW'(n_q);
		n19      = (nx << 4) + (nx << 1) + nx;
		tk_lo    = (p20 <= nx);
		tk_hi    = (p20 >= n19);
		is_tukey = (window_type == fwm_pkg::WIN_TUKEY);
		if (cmd.second) begin
			num_c = NW'(p_q) << 1;
			den_c = DSR_W'(n_q);
		end else if (is_tukey) begin
			num_c = tk_lo ? (nx - p20) : (p20 - n19);
			den_c = DSR_W'(n_q) << 1;
		end else begin
			num_c = NW'(p_q);
			den_c = DSR_W'(n_q);
		end
	end

	// shared divider
	logic                      div_start;
	logic [DVD_W-1:0]          div_dvd;
	logic [DSR_W-1:0]          div_dsr;
	logic                      div_done;
	logic [fwm_pkg::QUO_W-1:0] div_quo;

	// rounding of the registered product
	logic [PROD_W-1:0] rnd22;
	logic [PROD_W-1:0] rnd29;
	logic [MAG_W-1:0]  x_c;
	logic [MUL_W-1:0]  r32_c;
	logic [MAG_W-1:0]  r31_c;

	assign rnd22 = mul_q + (64'd1 << 22);
	assign rnd29 = mul_q + (64'd1 << 29);
	assign x_c   = rnd22[53:23];
	assign r32_c = rnd29[61:30];
	assign r31_c = rnd29[60:30];

	// Taylor term division: reciprocal product, then one correction step
	logic [fwm_pkg::TD_W-1:0]       td_c;
	logic [MUL_W-1:0]               tq0_c;
	logic [MUL_W+fwm_pkg::TD_W-1:0] tqd_c;
	logic [MUL_W-1:0]               trem_c;
	logic [MUL_W-1:0]               tq_c;

	always_comb begin
		td_c   = fwm_pkg::term_divisor(cmd.k);
		tq0_c  = mul_q[PROD_W-1:MUL_W];
		tqd_c  = tq0_c * td_c;
		trem_c = tv_q - tqd_c[MUL_W-1:0];
		tq_c   = (trem_c >= MUL_W'(td_c)) ? tq0_c + MUL_W'(1) : tq0_c;
	end

	always_comb begin
		div_start = 1'b0;
		div_dvd   = '0;
		div_dsr   = '0;
		unique case (cmd.op)
			fwm_pkg::OP_PHASE: begin
				div_start = 1'b1;
				div_dvd   = (DVD_W'(num_c) << fwm_pkg::PH_BITS) + DVD_W'(den_c >> 1);
				div_dsr   = den_c;
			end
			default: begin
				div_start = 1'b0;
			end
		endcase
	end

	fwm_div #(
		.DVD_W(DVD_W),
		.DSR_W(DSR_W)
	) u_div (
		.clk     (clk),
		.arst_n  (arst_n),
		.start   (div_start),
		.dividend(div_dvd),
		.divisor (div_dsr),
		.done    (div_done),
		.quotient(div_quo)
	);

	// cosine fold: quadrant and angle inside the first quarter turn
	logic [fwm_pkg::PH_BITS-1:0] u_c;
	logic [1:0]                  qd_c;
	logic [22:0]                 a_c;

	always_comb begin
		u_c  = div_quo[fwm_pkg::PH_BITS-1:0];
		qd_c = u_c[23:22];
		a_c  = qd_c[0] ? (23'h400000 - {1'b0, u_c[21:0]}) : {1'b0, u_c[21:0]};
	end

	// clamps, constant select, coefficient and final product
	logic [MAG_W-1:0]         cmag_c;
	logic [MAG_W-1:0]         kconst_c;
	logic                     ksub_c;
	logic [MAG_W-1:0]         wc_c;
	logic [MUL_W-1:0]         wsum_c;
	logic [COEF_WIDTH-1:0]    coef_c;
	logic                     s_neg;
	logic [SW-1:0]            sabs_c;
	logic signed [PROD_W-1:0] prod_s;
	logic signed [PROD_W-1:0] shr_s;
	logic signed [SW-1:0]     res_c;
	logic signed [ACC_W-1:0]  w_base_c;

	always_comb begin
		priority if (sum_q < 0) begin
			cmag_c = '0;
		end else if (sum_q > ONE_ACC) begin
			cmag_c = fwm_pkg::ONE30;
		end else begin
			cmag_c = MAG_W'(sum_q);
		end

		if (cmd.second) begin
			kconst_c = fwm_pkg::K_008;
		end else if (window_type == fwm_pkg::WIN_HAMMING) begin
			kconst_c = fwm_pkg::K_046;
		end else begin
			kconst_c = fwm_pkg::K_HALF;
		end
		// first cosine subtracts except for the Tukey fades; the second adds
		ksub_c = !cmd.second && !is_tukey;

		priority if (sts.flat) begin
			wc_c = fwm_pkg::ONE30;
		end else if (w_q < 0) begin
			wc_c = '0;
		end else if (w_q > ONE_ACC) begin
			wc_c = fwm_pkg::ONE30;
		end else begin
			wc_c = MAG_W'(w_q);
		end
		wsum_c = MUL_W'(wc_c) + (32'd1 << (29 - F));
		coef_c = COEF_WIDTH'(wsum_c >> (30 - F));

		s_neg  = s_q[SW-1];
		sabs_c = s_neg ? SW'(-s_q) : SW'(s_q);

		prod_s = s_neg ? -$signed(mul_q) : $signed(mul_q);
		shr_s  = (prod_s + HALF_LSB) >>> F;
		priority if (sts.pass) begin
			res_c = s_q;
		end else if (shr_s > SMAX) begin
			res_c = SW'(SMAX);
		end else if (shr_s < SMIN) begin
			res_c = SW'(SMIN);
		end else begin
			res_c = SW'(shr_s);
		end

		unique case (window_type)
			fwm_pkg::WIN_HAMMING:  w_base_c = ACC_W'(fwm_pkg::K_054);
			fwm_pkg::WIN_BLACKMAN: w_base_c = ACC_W'(fwm_pkg::K_042);
			default:               w_base_c = ACC_W'(fwm_pkg::K_HALF);
		endcase
	end

	// status
	always_comb begin
		sts.pass     = (n_q == '0) || (window_type == fwm_pkg::WIN_RECT)
			|| (window_type > fwm_pkg::WIN_TUKEY);
		sts.flat     = is_tukey && !tk_lo && !tk_hi;
		sts.two_cos  = (window_type == fwm_pkg::WIN_BLACKMAN);
		sts.div_done = div_done;
	end

	// position counter
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			pos_q <= '0;
		end else if (cmd.op == fwm_pkg::OP_LOAD) begin
			pos_q <= last_c ? '0 : PW'(p_c + 1'b1);
		end
	end

	// multiplier, registered
	always_ff @(posedge clk) begin
		mul_q <= opa_q * opb_q;
	end

	always_ff @(posedge clk) begin
		unique case (cmd.op)
			fwm_pkg::OP_LOAD: begin
				p_q    <= p_c;
				n_q    <= n_c;
				s_q    <= sample_in;
				last_q <= last_c;
				w_q    <= w_base_c;
			end
			fwm_pkg::OP_FOLD: begin
				qd_q  <= qd_c;
				opa_q <= MUL_W'(a_c);
				opb_q <= fwm_pkg::PI30;
			end
			fwm_pkg::OP_X: begin
				opa_q <= MUL_W'(x_c);
				opb_q <= MUL_W'(x_c);
			end
			fwm_pkg::OP_X2: begin
				x2_q  <= r32_c;
				sum_q <= ONE_ACC;
				opa_q <= MUL_W'(fwm_pkg::ONE30);
				opb_q <= r32_c;
			end
			fwm_pkg::OP_TDIV: begin
				tv_q  <= r32_c;
				opa_q <= r32_c;
				opb_q <= fwm_pkg::term_recip(cmd.k);
			end
			fwm_pkg::OP_TACC: begin
				if (cmd.k[0]) begin
					sum_q <= sum_q - $signed(ACC_W'(tq_c));
				end else begin
					sum_q <= sum_q + $signed(ACC_W'(tq_c));
				end
				opa_q <= tq_c;
				opb_q <= x2_q;
			end
			fwm_pkg::OP_CEND: begin
				c_mag_q <= cmag_c;
				c_neg_q <= (qd_q == 2'd1) || (qd_q == 2'd2);
			end
			fwm_pkg::OP_KMUL: begin
				opa_q <= MUL_W'(kconst_c);
				opb_q <= MUL_W'(c_mag_q);
			end
			fwm_pkg::OP_KACC: begin
				if (ksub_c ^ c_neg_q) begin
					w_q <= w_q - $signed(ACC_W'(r31_c));
				end else begin
					w_q <= w_q + $signed(ACC_W'(r31_c));
				end
			end
			fwm_pkg::OP_COEF: begin
				opa_q <= MUL_W'(sabs_c);
				opb_q <= MUL_W'(coef_c);
			end
			fwm_pkg::OP_RES: begin
				sample_out_q <= res_c;
				frame_last_q <= last_q;
			end
			default: begin
			end
		endcase
	end

	assign sample_out = sample_out_q;
	assign frame_last = frame_last_q;

endmodule

[rtl/fwm_ctrl.sv]
// ----------------------------------------------------------------------------
// Frame window multiplier controller
// Sequencer that steps the datapath through one item and owns both
// handshakes.
// ----------------------------------------------------------------------------
module fwm_ctrl (
	input  logic          clk,
	input  logic          arst_n,
	input  logic          in_valid,
	output logic          in_stall,
	output logic          out_valid,
	input  logic          out_stall,
	input  fwm_pkg::sts_t sts,
	output fwm_pkg::cmd_t cmd
);

	fwm_pkg::state_t                state_q;
	fwm_pkg::state_t                state_d;
	logic [fwm_pkg::K_W-1:0]        k_q;
	logic                           second_q;
	logic                           out_valid_q;

	always_comb begin
		state_d    = state_q;
		cmd.op     = fwm_pkg::OP_NONE;
		cmd.second = second_q;
		cmd.k      = k_q;
		unique case (state_q)
			fwm_pkg::S_IDLE: begin
				if (in_valid) begin
					cmd.op  = fwm_pkg::OP_LOAD;
					state_d = fwm_pkg::S_SETUP;
				end
			end
			fwm_pkg::S_SETUP: begin
				priority if (sts.pass) begin
					state_d = fwm_pkg::S_RES;
				end else if (sts.flat) begin
					state_d = fwm_pkg::S_COEF;
				end else begin
					state_d = fwm_pkg::S_PHASE;
				end
			end
			fwm_pkg::S_PHASE: begin
				cmd.op  = fwm_pkg::OP_PHASE;
				state_d = fwm_pkg::S_PWAIT;
			end
			fwm_pkg::S_PWAIT: begin
				if (sts.div_done) begin
					state_d = fwm_pkg::S_FOLD;
				end
			end
			fwm_pkg::S_FOLD: begin
				cmd.op  = fwm_pkg::OP_FOLD;
				state_d = fwm_pkg::S_FOLD_W;
			end
			fwm_pkg::S_FOLD_W: state_d = fwm_pkg::S_X;
			fwm_pkg::S_X: begin
				cmd.op  = fwm_pkg::OP_X;
				state_d = fwm_pkg::S_X_W;
			end
			fwm_pkg::S_X_W: state_d = fwm_pkg::S_X2;
			fwm_pkg::S_X2: begin
				cmd.op  = fwm_pkg::OP_X2;
				state_d = fwm_pkg::S_TM_W;
			end
			fwm_pkg::S_TM_W: state_d = fwm_pkg::S_TDIV;
			fwm_pkg::S_TDIV: begin
				cmd.op  = fwm_pkg::OP_TDIV;
				state_d = fwm_pkg::S_TWAIT;
			end
			fwm_pkg::S_TWAIT: state_d = fwm_pkg::S_TACC;
			fwm_pkg::S_TACC: begin
				cmd.op  = fwm_pkg::OP_TACC;
				state_d = (k_q == fwm_pkg::N_TERMS) ? fwm_pkg::S_CEND : fwm_pkg::S_TM_W;
			end
			fwm_pkg::S_CEND: begin
				cmd.op  = fwm_pkg::OP_CEND;
				state_d = fwm_pkg::S_KMUL;
			end
			fwm_pkg::S_KMUL: begin
				cmd.op  = fwm_pkg::OP_KMUL;
				state_d = fwm_pkg::S_KM_W;
			end
			fwm_pkg::S_KM_W: state_d = fwm_pkg::S_KACC;
			fwm_pkg::S_KACC: begin
				cmd.op  = fwm_pkg::OP_KACC;
				state_d = (sts.two_cos && !second_q) ? fwm_pkg::S_PHASE : fwm_pkg::S_COEF;
			end
			fwm_pkg::S_COEF: begin
				cmd.op  = fwm_pkg::OP_COEF;
				state_d = fwm_pkg::S_CO_W;
			end
			fwm_pkg::S_CO_W: state_d = fwm_pkg::S_RES;
			fwm_pkg::S_RES: begin
				if (!out_valid_q || !out_stall) begin
					cmd.op  = fwm_pkg::OP_RES;
					state_d = fwm_pkg::S_IDLE;
				end
			end
			default: state_d = fwm_pkg::S_IDLE;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= fwm_pkg::S_IDLE;
			k_q         <= '0;
			second_q    <= 1'b0;
			out_valid_q <= 1'b0;
		end else begin
			state_q     <= state_d;
			out_valid_q <= (cmd.op == fwm_pkg::OP_RES) || (out_valid_q && out_stall);
			if (cmd.op == fwm_pkg::OP_LOAD) begin
				second_q <= 1'b0;
			end else if (cmd.op == fwm_pkg::OP_KACC) begin
				second_q <= 1'b1;
			end
			if (cmd.op == fwm_pkg::OP_X2) begin
				k_q <= fwm_pkg::K_W'(1);
			end else if (cmd.op == fwm_pkg::OP_TACC) begin
				k_q <= k_q + 1'b1;
			end
		end
	end

	assign in_stall  = (state_q != fwm_pkg::S_IDLE);
	assign out_valid = out_valid_q;

endmodule

[rtl/frame_window_multiplier_top.sv]
// ----------------------------------------------------------------------------
// Frame window multiplier
// Multiplies each audio sample by a rectangular, Hann, Hamming, Blackman or
// Tukey window coefficient picked by its position in the frame.
// ----------------------------------------------------------------------------
// Usage:
//   Input channel: in_valid/in_stall with sample_in and frame_start. An item
//   is taken when in_valid is high and in_stall low. frame_start puts the
//   item at position zero of a new frame.
//   Output channel: out_valid/out_stall with sample_out and frame_last, one
//   result item for every input item, in order.
//   Configuration: write window_type (index 0) or frame_length (index 1) via
//   cfg_we/cfg_index/cfg_data, only while no item is in flight.
//   Timing: one item at a time; the next item can be taken as soon as
//   out_valid rises. Pass-through (rectangular, unknown type, frame length
//   one) and the flat middle of a Tukey window skip the cosine. Each cosine
//   runs a phase division on the 4-bit-per-cycle divider, a fold and a
//   square, seven Taylor terms (reciprocal multiply per term) and a scale.
//   Hann, Hamming and the Tukey fades use one cosine; Blackman uses two.
//   A finished item waits in the output register; the next input item is
//   accepted while it is stalled there. Reset clears the position counter,
//   sets window_type to Hann and frame_length to 1024, and empties the
//   output register.
// ----------------------------------------------------------------------------
module frame_window_multiplier_top #(
	parameter int MAX_FRAME    = 4096,
	parameter int SAMPLE_WIDTH = 24,
	parameter int COEF_WIDTH   = 18
) (
	input  logic                              clk,
	input  logic                              arst_n,
	// input channel
	input  logic                              in_valid,
	output logic                              in_stall,
	input  logic signed [SAMPLE_WIDTH-1:0]    sample_in,
	input  logic                              frame_start,
	// output channel
	output logic                              out_valid,
	input  logic                              out_stall,
	output logic signed [SAMPLE_WIDTH-1:0]    sample_out,
	output logic                              frame_last,
	// configuration write port
	input  logic                              cfg_we,
	input  logic [fwm_pkg::CFG_IDX_W-1:0]     cfg_index,
	input  logic [fwm_pkg::CFG_W-1:0]         cfg_data
);

	logic [fwm_pkg::WT_W-1:0] window_type_q;
	logic [fwm_pkg::FL_W-1:0] frame_length_q;

	fwm_pkg::cmd_t cmd;
	fwm_pkg::sts_t sts;

	// configuration registers: keep the low bits of the written word
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			window_type_q  <= fwm_pkg::WT_RESET;
			frame_length_q <= fwm_pkg::FL_RESET;
		end else if (cfg_we) begin
			unique case (cfg_index)
				fwm_pkg::REG_WINDOW_TYPE:  window_type_q  <= cfg_data[fwm_pkg::WT_W-1:0];
				fwm_pkg::REG_FRAME_LENGTH: frame_length_q <= cfg_data[fwm_pkg::FL_W-1:0];
				default: begin
				end
			endcase
		end
	end

	// sequencer: owns both handshakes and issues at most one datapath op per cycle
	fwm_ctrl u_ctrl (
		.clk      (clk),
		.arst_n   (arst_n),
		.in_valid (in_valid),
		.in_stall (in_stall),
		.out_valid(out_valid),
		.out_stall(out_stall),
		.sts      (sts),
		.cmd      (cmd)
	);

	// arithmetic: position counter, cosine unit, window and scaling
	fwm_dp #(
		.MAX_FRAME   (MAX_FRAME),
		.SAMPLE_WIDTH(SAMPLE_WIDTH),
		.COEF_WIDTH  (COEF_WIDTH)
	) u_dp (
		.clk         (clk),
		.arst_n      (arst_n),
		.cmd         (cmd),
		.sts         (sts),
		.window_type (window_type_q),
		.frame_length(frame_length_q),
		.sample_in   (sample_in),
		.frame_start (frame_start),
		.sample_out  (sample_out),
		.frame_last  (frame_last)
	);

endmodule
